// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KMT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define KMT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hdl/kmt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmt_pkg
// Types, codes and defaults shared by the keyed move table modules.
// ----------------------------------------------------------------------------
package kmt_pkg;

   localparam int KMT_KEY_ROWS      = 256;
   localparam int KMT_MOVES_PER_KEY = 8;

   typedef enum logic [1:0] {
      CMD_UPDATE     = 2'd0,
      CMD_PROBE_KEY  = 2'd1,
      CMD_PROBE_MOVE = 2'd2,
      CMD_CLEAR      = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_NEW_KEY   = 3'd0,
      ST_NEW_MOVE  = 3'd1,
      ST_REPLACED  = 3'd2,
      ST_UNCHANGED = 3'd3,
      ST_FOUND     = 3'd4,
      ST_NOT_FOUND = 3'd5,
      ST_FULL      = 3'd6,
      ST_CLEARED   = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_ROW,
      S_CNT,
      S_SLOT,
      S_EXEC,
      S_WR2,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [15:0]        move;
      logic [7:0]         depth;
      logic signed [15:0] score;
   } entry_type;

   typedef struct packed {
      logic row_key_we;
      logic row_cnt_we;
      logic ent_we;
   } mem_ctl_type;

endpackage

// ----- hdl/kmt_row_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmt_row_store
// Row key and move count memories, one read and one write port each.
// ----------------------------------------------------------------------------
module kmt_row_store import kmt_pkg::*; #(
   parameter int KEY_ROWS = KMT_KEY_ROWS,
   parameter int CW       = 4,
   localparam int RW      = $clog2(KEY_ROWS)
) (
   input  logic            clock,
   input  mem_ctl_type     mem_ctl,
   input  logic [RW-1:0]   rd_addr,
   input  logic [RW-1:0]   wr_addr,
   input  logic [63:0]     wr_key,
   input  logic [CW-1:0]   wr_cnt,
   output logic [63:0]     rd_key,
   output logic [CW-1:0]   rd_cnt
);

   logic [63:0]   key_mem [KEY_ROWS];
   logic [CW-1:0] cnt_mem [KEY_ROWS];

   always_ff @(posedge clock) begin
      if (mem_ctl.row_key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (mem_ctl.row_cnt_we) begin
         cnt_mem[wr_addr] <= wr_cnt;
      end
      rd_key <= key_mem[rd_addr];
      rd_cnt <= cnt_mem[rd_addr];
   end

endmodule

// ----- hdl/kmt_entry_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmt_entry_store
// Move entry memory (move, depth, score), one read and one write port.
// ----------------------------------------------------------------------------
module kmt_entry_store import kmt_pkg::*; #(
   parameter int DEPTH = KMT_KEY_ROWS * KMT_MOVES_PER_KEY,
   localparam int EAW  = $clog2(DEPTH)
) (
   input  logic           clock,
   input  mem_ctl_type    mem_ctl,
   input  logic [EAW-1:0] rd_addr,
   input  logic [EAW-1:0] wr_addr,
   input  entry_type      wr_data,
   output entry_type      rd_data
);

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_ctl.ent_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hdl/kmt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmt_ctrl
// Sequencer: row scan, slot scan, update decision and write-back.
// ----------------------------------------------------------------------------
module kmt_ctrl import kmt_pkg::*; #(
   parameter int KEY_ROWS      = KMT_KEY_ROWS,
   parameter int MOVES_PER_KEY = KMT_MOVES_PER_KEY,
   localparam int RW  = $clog2(KEY_ROWS),
   localparam int CW  = $clog2(MOVES_PER_KEY + 1),
   localparam int SLW = $clog2(MOVES_PER_KEY),
   localparam int EAW = $clog2(KEY_ROWS * MOVES_PER_KEY)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [63:0]        req_key,
   input  logic [15:0]        req_move_code,
   input  logic [7:0]         req_depth,
   input  logic signed [15:0] req_score,
   input  logic               csr_we,
   input  logic               csr_wdata,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_found_move,
   output logic [7:0]         rsp_found_depth,
   output logic signed [15:0] rsp_found_score,
   output logic [3:0]         rsp_move_count,
   output logic               rsp_promoted,
   output logic               rsp_dirty_flag,
   output mem_ctl_type        mem_ctl,
   output logic [RW-1:0]      row_rd_addr,
   output logic [RW-1:0]      row_wr_addr,
   output logic [63:0]        row_wr_key,
   output logic [CW-1:0]      row_wr_cnt,
   input  logic [63:0]        row_rd_key,
   input  logic [CW-1:0]      row_rd_cnt,
   output logic [EAW-1:0]     ent_rd_addr,
   output logic [EAW-1:0]     ent_wr_addr,
   output entry_type          ent_wr_data,
   input  entry_type          ent_rd_data
);

   state_type state_ff, state_in;

   logic                q_ff;
   logic                dirty_ff;
   logic [KEY_ROWS-1:0] valid_ff;

   cmd_type       cmd_ff;
   logic [63:0]   key_ff;
   entry_type     offer_ff;
   logic [RW:0]   scan_ff;
   logic          pend_ff;
   logic [RW-1:0] pidx_ff;
   logic          hit_ff;
   logic [RW-1:0] hrow_ff;
   logic          free_ok_ff;
   logic [RW-1:0] frow_ff;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] slot_ff;
   logic          spend_ff;
   logic [CW-1:0] sidx_ff;
   entry_type     ent0_ff;
   logic          mfound_ff;
   logic [CW-1:0] midx_ff;
   entry_type     ment_ff;
   logic [SLW-1:0] w2_slot_ff;
   entry_type     w2_data_ff;

   status_type    res_status_ff;
   entry_type     res_ent_ff;
   logic [3:0]    res_cnt_ff;
   logic          res_prom_ff;

   logic          rsp_valid_ff;
   status_type    rsp_status_ff;
   entry_type     rsp_ent_ff;
   logic [3:0]    rsp_cnt_ff;
   logic          rsp_prom_ff;
   logic          rsp_dirty_ff;

   status_type     d_status;
   entry_type      d_ent;
   logic [CW-1:0]  d_cnt;
   logic           d_prom;
   logic           d_w1_en;
   logic [SLW-1:0] d_w1_slot;
   entry_type      d_w1_data;
   logic           d_w2_en;
   logic [SLW-1:0] d_w2_slot;
   entry_type      d_w2_data;
   logic           d_row_key_we;
   logic           d_row_cnt_we;
   logic           d_dirty;
   logic [RW-1:0]  wrow;
   logic [CW+3:0]  cnt_ext;
   logic           accept;
   logic           scan_done;
   logic           slot_done;
   logic           out_free;

   function automatic logic [EAW-1:0] ent_addr(input logic [RW-1:0] row,
                                               input logic [SLW-1:0] slot);
      ent_addr = EAW'(row) * EAW'(MOVES_PER_KEY) + EAW'(slot);
   endfunction

   function automatic logic beats(input entry_type c, input entry_type b, input logic q);
      if (q) begin
         beats = c.score > b.score;
      end else begin
         beats = (b.depth < c.depth) || (b.depth == c.depth && b.score <= c.score);
      end
   endfunction

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign scan_done = (scan_ff == (RW+1)'(KEY_ROWS)) && !pend_ff;
   assign slot_done = (slot_ff == n_ff) && !spend_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign wrow      = hit_ff ? hrow_ff : frow_ff;
   assign cnt_ext   = {4'b0, d_cnt};

   always_comb begin
      d_status     = ST_NOT_FOUND;
      d_ent        = '0;
      d_cnt        = '0;
      d_prom       = 1'b0;
      d_w1_en      = 1'b0;
      d_w1_slot    = '0;
      d_w1_data    = offer_ff;
      d_w2_en      = 1'b0;
      d_w2_slot    = midx_ff[SLW-1:0];
      d_w2_data    = ent0_ff;
      d_row_key_we = 1'b0;
      d_row_cnt_we = 1'b0;
      d_dirty      = 1'b0;
      case (cmd_ff)
         CMD_PROBE_KEY: begin
            if (hit_ff) begin
               d_status = ST_FOUND;
               d_ent    = ent0_ff;
               d_cnt    = n_ff;
            end
         end
         CMD_PROBE_MOVE: begin
            d_cnt = hit_ff ? n_ff : '0;
            if (hit_ff && mfound_ff) begin
               d_status = ST_FOUND;
               d_ent    = ment_ff;
            end
         end
         CMD_UPDATE: begin
            if (!hit_ff) begin
               if (free_ok_ff) begin
                  d_status     = ST_NEW_KEY;
                  d_ent        = offer_ff;
                  d_cnt        = CW'(1);
                  d_w1_en      = 1'b1;
                  d_row_key_we = 1'b1;
                  d_row_cnt_we = 1'b1;
                  d_dirty      = 1'b1;
               end else begin
                  d_status = ST_FULL;
               end
            end else if (!mfound_ff) begin
               if (n_ff >= CW'(MOVES_PER_KEY)) begin
                  d_status = ST_FULL;
                  d_ent    = ent0_ff;
                  d_cnt    = n_ff;
               end else begin
                  d_status     = ST_NEW_MOVE;
                  d_cnt        = n_ff + CW'(1);
                  d_row_cnt_we = 1'b1;
                  d_dirty      = 1'b1;
                  d_w1_en      = 1'b1;
                  d_prom       = beats(offer_ff, ent0_ff, q_ff);
                  d_w2_slot    = n_ff[SLW-1:0];
                  if (d_prom) begin
                     d_w2_en = 1'b1;
                     d_ent   = offer_ff;
                  end else begin
                     d_w1_slot = n_ff[SLW-1:0];
                     d_ent     = ent0_ff;
                  end
               end
            end else begin
               d_cnt = n_ff;
               if (ment_ff.depth < offer_ff.depth ||
                   (ment_ff.depth == offer_ff.depth && ment_ff.score < offer_ff.score)) begin
                  d_status = ST_REPLACED;
                  d_dirty  = 1'b1;
                  d_w1_en  = 1'b1;
                  if (midx_ff == '0) begin
                     d_ent = offer_ff;
                  end else begin
                     d_prom = beats(offer_ff, ent0_ff, q_ff);
                     if (d_prom) begin
                        d_w2_en = 1'b1;
                        d_ent   = offer_ff;
                     end else begin
                        d_w1_slot = midx_ff[SLW-1:0];
                        d_ent     = ent0_ff;
                     end
                  end
               end else begin
                  d_status = ST_UNCHANGED;
                  d_ent    = ent0_ff;
               end
            end
         end
         default: begin
            d_status = ST_CLEARED;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (cmd_type'(req_cmd) == CMD_CLEAR) ? S_OUT : S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_ROW;
            end
         end
         S_ROW:  state_in = hit_ff ? S_CNT : S_EXEC;
         S_CNT:  state_in = S_SLOT;
         S_SLOT: begin
            if (slot_done) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: state_in = d_w2_en ? S_WR2 : S_OUT;
         S_WR2:  state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_stall          = (state_ff != S_IDLE);
      mem_ctl.row_key_we = (state_ff == S_EXEC) && d_row_key_we;
      mem_ctl.row_cnt_we = (state_ff == S_EXEC) && d_row_cnt_we;
      mem_ctl.ent_we     = ((state_ff == S_EXEC) && d_w1_en) || (state_ff == S_WR2);
      row_rd_addr        = (state_ff == S_SCAN) ? scan_ff[RW-1:0] : hrow_ff;
      row_wr_addr        = wrow;
      row_wr_key         = key_ff;
      row_wr_cnt         = d_cnt;
      ent_rd_addr        = ent_addr(hrow_ff, slot_ff[SLW-1:0]);
      if (state_ff == S_WR2) begin
         ent_wr_addr = ent_addr(wrow, w2_slot_ff);
         ent_wr_data = w2_data_ff;
      end else begin
         ent_wr_addr = ent_addr(wrow, d_w1_slot);
         ent_wr_data = d_w1_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         q_ff         <= 1'b0;
         dirty_ff     <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            q_ff <= csr_wdata;
         end
         if (accept && cmd_type'(req_cmd) == CMD_CLEAR) begin
            valid_ff <= '0;
            dirty_ff <= 1'b0;
         end
         if (state_ff == S_EXEC) begin
            if (d_dirty) begin
               dirty_ff <= 1'b1;
            end
            if (d_row_key_we) begin
               valid_ff[frow_ff] <= 1'b1;
            end
         end
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            cmd_ff         <= cmd_type'(req_cmd);
            key_ff         <= req_key;
            offer_ff.move  <= req_move_code;
            offer_ff.depth <= req_depth;
            offer_ff.score <= req_score;
            scan_ff        <= '0;
            pend_ff        <= 1'b0;
            hit_ff         <= 1'b0;
            free_ok_ff     <= 1'b0;
            res_status_ff  <= ST_CLEARED;
            res_ent_ff     <= '0;
            res_cnt_ff     <= '0;
            res_prom_ff    <= 1'b0;
         end
         S_SCAN: begin
            if (scan_ff != (RW+1)'(KEY_ROWS)) begin
               pend_ff <= 1'b1;
               pidx_ff <= scan_ff[RW-1:0];
               scan_ff <= scan_ff + (RW+1)'(1);
            end else begin
               pend_ff <= 1'b0;
            end
            if (pend_ff) begin
               if (valid_ff[pidx_ff] && row_rd_key == key_ff && !hit_ff) begin
                  hit_ff  <= 1'b1;
                  hrow_ff <= pidx_ff;
               end
               if (!valid_ff[pidx_ff] && !free_ok_ff) begin
                  free_ok_ff <= 1'b1;
                  frow_ff    <= pidx_ff;
               end
            end
         end
         S_CNT: begin
            n_ff      <= row_rd_cnt;
            slot_ff   <= '0;
            spend_ff  <= 1'b0;
            mfound_ff <= 1'b0;
         end
         S_SLOT: begin
            if (slot_ff != n_ff) begin
               spend_ff <= 1'b1;
               sidx_ff  <= slot_ff;
               slot_ff  <= slot_ff + CW'(1);
            end else begin
               spend_ff <= 1'b0;
            end
            if (spend_ff) begin
               if (sidx_ff == '0) begin
                  ent0_ff <= ent_rd_data;
               end
               if (!mfound_ff && ent_rd_data.move == offer_ff.move) begin
                  mfound_ff <= 1'b1;
                  midx_ff   <= sidx_ff;
                  ment_ff   <= ent_rd_data;
               end
            end
         end
         S_EXEC: begin
            res_status_ff <= d_status;
            res_ent_ff    <= d_ent;
            res_cnt_ff    <= cnt_ext[3:0];
            res_prom_ff   <= d_prom;
            w2_slot_ff    <= d_w2_slot;
            w2_data_ff    <= d_w2_data;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_status_ff <= res_status_ff;
               rsp_ent_ff    <= res_ent_ff;
               rsp_cnt_ff    <= res_cnt_ff;
               rsp_prom_ff   <= res_prom_ff;
               rsp_dirty_ff  <= dirty_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_move  = rsp_ent_ff.move;
   assign rsp_found_depth = rsp_ent_ff.depth;
   assign rsp_found_score = rsp_ent_ff.score;
   assign rsp_move_count  = rsp_cnt_ff;
   assign rsp_promoted    = rsp_prom_ff;
   assign rsp_dirty_flag  = rsp_dirty_ff;

endmodule

// ----- hdl/keyed_move_table_best_first_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_move_table_best_first_top
// Table of position keys with up to MOVES_PER_KEY move entries per key,
// slot 0 kept as the best entry.
// ----------------------------------------------------------------------------
// One transaction at a time. A lookup or update walks every row of the key
// memory, one row per cycle through its single read port; when the key is
// found it reads the move count and walks the key's slots through the entry
// memory port. It finishes in the decision state, which does the writes of an
// update, plus a second write state when a promotion needs it, then loads the
// result in the output state. A clear goes straight to the output state.
// Results sit in an output register, so the next transaction is taken while
// one waits.
module keyed_move_table_best_first_top import kmt_pkg::*; #(
   parameter int KEY_ROWS      = KMT_KEY_ROWS,
   parameter int MOVES_PER_KEY = KMT_MOVES_PER_KEY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [63:0]        req_key,
   input  logic [15:0]        req_move_code,
   input  logic [7:0]         req_depth,
   input  logic signed [15:0] req_score,
   input  logic               csr_we,
   input  logic               csr_wdata,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_found_move,
   output logic [7:0]         rsp_found_depth,
   output logic signed [15:0] rsp_found_score,
   output logic [3:0]         rsp_move_count,
   output logic               rsp_promoted,
   output logic               rsp_dirty_flag
);

   localparam int RW  = $clog2(KEY_ROWS);
   localparam int CW  = $clog2(MOVES_PER_KEY + 1);
   localparam int EAW = $clog2(KEY_ROWS * MOVES_PER_KEY);

   mem_ctl_type    mem_ctl;
   logic [RW-1:0]  row_rd_addr;
   logic [RW-1:0]  row_wr_addr;
   logic [63:0]    row_wr_key;
   logic [CW-1:0]  row_wr_cnt;
   logic [63:0]    row_rd_key;
   logic [CW-1:0]  row_rd_cnt;
   logic [EAW-1:0] ent_rd_addr;
   logic [EAW-1:0] ent_wr_addr;
   entry_type      ent_wr_data;
   entry_type      ent_rd_data;

   kmt_ctrl #(
      .KEY_ROWS      (KEY_ROWS),
      .MOVES_PER_KEY (MOVES_PER_KEY)
   ) u_ctrl (
      .clock, .reset,
      .req_valid, .req_stall, .req_cmd, .req_key, .req_move_code, .req_depth, .req_score,
      .csr_we, .csr_wdata,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_found_move, .rsp_found_depth,
      .rsp_found_score, .rsp_move_count, .rsp_promoted, .rsp_dirty_flag,
      .mem_ctl, .row_rd_addr, .row_wr_addr, .row_wr_key, .row_wr_cnt,
      .row_rd_key, .row_rd_cnt, .ent_rd_addr, .ent_wr_addr, .ent_wr_data, .ent_rd_data
   );

   kmt_row_store #(
      .KEY_ROWS (KEY_ROWS),
      .CW       (CW)
   ) u_row_store (
      .clock,
      .mem_ctl,
      .rd_addr (row_rd_addr),
      .wr_addr (row_wr_addr),
      .wr_key  (row_wr_key),
      .wr_cnt  (row_wr_cnt),
      .rd_key  (row_rd_key),
      .rd_cnt  (row_rd_cnt)
   );

   kmt_entry_store #(
      .DEPTH (KEY_ROWS * MOVES_PER_KEY)
   ) u_entry_store (
      .clock,
      .mem_ctl,
      .rd_addr (ent_rd_addr),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_data (ent_rd_data)
   );

endmodule

// ----- hdl/kmt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmt_checker
// Port-level checks on the keyed move table result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kmt_checker import kmt_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_status,
   input logic [15:0]        rsp_found_move,
   input logic [7:0]         rsp_found_depth,
   input logic signed [15:0] rsp_found_score,
   input logic [3:0]         rsp_move_count,
   input logic               rsp_promoted,
   input logic               rsp_dirty_flag
);

   `KMT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status))
   `KMT_ASSERT_NOW(a_clear_empty, rsp_valid && rsp_status == ST_CLEARED, !rsp_dirty_flag && rsp_move_count == 4'd0)
   `KMT_ASSERT_NOW(a_change_dirty, rsp_valid && (rsp_status == ST_NEW_KEY || rsp_status == ST_NEW_MOVE || rsp_status == ST_REPLACED), rsp_dirty_flag)
   `KMT_ASSERT_NOW(a_promote_kind, rsp_valid && rsp_promoted, rsp_status == ST_NEW_MOVE || rsp_status == ST_REPLACED)
   `KMT_ASSERT_NOW(a_miss_zero, rsp_valid && rsp_status == ST_NOT_FOUND, rsp_found_move == 16'd0 && rsp_found_depth == 8'd0 && rsp_found_score == 16'sd0)

endmodule

bind keyed_move_table_best_first_top kmt_checker u_checker (.*);
